>>> rtl/rrcc_pkg.sv
// Package for the running rank cost counter: item structs, the tag that
// travels down the compare chain, and the fixed output limits.
// No dependencies.
`default_nettype none

package rrcc_pkg;

    // Input item: one value of the sequence and a restart flag
    typedef struct packed {
        logic [15:0] value;
        logic        restart;
    } rrcc_in_t;

    // Result item
    typedef struct packed {
        logic [9:0]  lesser_count;
        logic [9:0]  greater_count;
        logic [8:0]  item_cost;
        logic [29:0] total_cost;
        logic        full_res;
    } rrcc_out_t;

    // Control tag carried with each item through the chain
    typedef struct packed {
        logic valid;
        logic full;
        logic restart;
    } rrcc_tag_t;

    localparam logic [9:0]  COUNT_FIELD_MAX = 10'd1023;
    localparam logic [8:0]  COST_FIELD_MAX  = 9'd511;
    localparam logic [29:0] COST_MODULUS    = 30'd1000000007;

endpackage

`default_nettype wire

>>> rtl/rrcc_cell.sv
// One compare cell of the chain: holds one stored value and counts it
// against each passing item. Depends on rrcc_pkg.
`default_nettype none

module rrcc_cell #(
    parameter int INDEX = 0,
    parameter int SW    = 16,
    parameter int IW    = 11
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      adv,
    input  rrcc_pkg::rrcc_tag_t      tag_in,
    input  wire [SW-1:0]             value_in,
    input  wire [IW-1:0]             idx_in,
    input  wire [IW-1:0]             lesser_in,
    input  wire [IW-1:0]             greater_in,
    output rrcc_pkg::rrcc_tag_t      tag_out,
    output logic [SW-1:0]            value_out,
    output logic [IW-1:0]            idx_out,
    output logic [IW-1:0]            lesser_out,
    output logic [IW-1:0]            greater_out
);
    import rrcc_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    rrcc_tag_t     tag_reg;
    logic [SW-1:0] stored_reg;
    logic [SW-1:0] value_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] lesser_reg;
    logic [IW-1:0] greater_reg;

    logic          live;
    logic          in_seq;
    logic          is_less;
    logic          is_greater;
    logic          do_write;
    logic [IW-1:0] lesser_next;
    logic [IW-1:0] greater_next;

    // Compare against the stored value only if it belongs to the item's sequence
    always_comb begin
        live         = tag_in.valid && !tag_in.full;
        in_seq       = live && (MY_IDX < idx_in);
        is_less      = in_seq && (stored_reg < value_in);
        is_greater   = in_seq && (stored_reg > value_in);
        do_write     = live && (idx_in == MY_IDX);
        lesser_next  = lesser_in + IW'(is_less);
        greater_next = greater_in + IW'(is_greater);
    end

    // Advance the tag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (adv) begin
            tag_reg <= tag_in;
        end
    end

    // Advance the payload and store the value at this item's slot
    always_ff @(posedge aclk) begin
        if (adv) begin
            value_reg   <= value_in;
            idx_reg     <= idx_in;
            lesser_reg  <= lesser_next;
            greater_reg <= greater_next;
            if (do_write) begin
                stored_reg <= value_in;
            end
        end
    end

    assign tag_out     = tag_reg;
    assign value_out   = value_reg;
    assign idx_out     = idx_reg;
    assign lesser_out  = lesser_reg;
    assign greater_out = greater_reg;

endmodule

`default_nettype wire

>>> rtl/rrcc_total.sv
// Chain tail: takes the counts, keeps the running total modulo
// 1000000007 and holds the result register. Depends on rrcc_pkg.
`default_nettype none

module rrcc_total #(
    parameter int IW = 11
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  rrcc_pkg::rrcc_tag_t      tag_in,
    input  wire [IW-1:0]             lesser_in,
    input  wire [IW-1:0]             greater_in,
    output logic                     adv,
    output logic                     m_valid,
    input  wire                      m_ready,
    output rrcc_pkg::rrcc_out_t      m_data
);
    import rrcc_pkg::*;

    localparam int EW = (IW > 10) ? IW : 10;

    logic          m_valid_reg;
    logic [29:0]   total_reg;
    rrcc_out_t     data_reg;

    logic [IW-1:0] cost;
    logic [29:0]   base;
    logic [30:0]   sum;
    logic [29:0]   total_next;
    logic [EW-1:0] lesser_ext;
    logic [EW-1:0] greater_ext;
    logic [EW-1:0] cost_ext;
    rrcc_out_t     data_next;

    // Chain moves whenever the result slot is free or being emptied
    assign adv = !m_valid_reg || m_ready;

    // Add the cost modulo the constant; one subtract suffices below twice it
    always_comb begin
        cost       = (lesser_in < greater_in) ? lesser_in : greater_in;
        base       = tag_in.restart ? 30'd0 : total_reg;
        sum        = {1'b0, base} + 31'(cost);
        if (sum >= {1'b0, COST_MODULUS}) begin
            sum = sum - {1'b0, COST_MODULUS};
        end
        total_next = tag_in.full ? base : sum[29:0];

        lesser_ext  = EW'(lesser_in);
        greater_ext = EW'(greater_in);
        cost_ext    = EW'(cost);

        data_next.lesser_count  = (lesser_ext > EW'(COUNT_FIELD_MAX)) ?
                                  COUNT_FIELD_MAX : lesser_ext[9:0];
        data_next.greater_count = (greater_ext > EW'(COUNT_FIELD_MAX)) ?
                                  COUNT_FIELD_MAX : greater_ext[9:0];
        data_next.item_cost     = (cost_ext > EW'(COST_FIELD_MAX)) ?
                                  COST_FIELD_MAX : cost_ext[8:0];
        data_next.total_cost    = total_next;
        data_next.full_res      = tag_in.full;
        if (tag_in.full) begin
            data_next.lesser_count  = '0;
            data_next.greater_count = '0;
            data_next.item_cost     = '0;
        end
    end

    // Hold the running total and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
        end else if (adv) begin
            m_valid_reg <= tag_in.valid;
            if (tag_in.valid) begin
                total_reg <= total_next;
            end
        end
    end

    // Load the result item
    always_ff @(posedge aclk) begin
        if (adv && tag_in.valid) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/running_rank_cost_counter.sv
// Running rank cost counter: a row of MAX_ITEMS compare cells and a total stage.
// Each item passes through the register of every cell, then the result register.
// Throughput: one item per cycle; the chain stalls only while a result waits.
// Each cell holds one stored value; the item visits one cell per cycle unless the chain stalls.
// Reset (synchronous, aresetn low) clears fill count, total and valid tags.
`default_nettype none

module running_rank_cost_counter #(
    parameter int MAX_ITEMS  = 1024,
    parameter int VALUE_BITS = 16
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  rrcc_pkg::rrcc_in_t       s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output rrcc_pkg::rrcc_out_t      m_data
);
    import rrcc_pkg::*;

    localparam int SW = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam logic [IW-1:0] FILL_LIMIT = IW'(MAX_ITEMS);

    logic          adv;
    logic [IW-1:0] fill_reg;
    logic [IW-1:0] fill_next;
    logic [IW-1:0] fill_base;
    logic          is_full;
    rrcc_tag_t     head_tag;

    rrcc_tag_t     tag_w     [MAX_ITEMS+1];
    logic [SW-1:0] value_w   [MAX_ITEMS+1];
    logic [IW-1:0] idx_w     [MAX_ITEMS+1];
    logic [IW-1:0] lesser_w  [MAX_ITEMS+1];
    logic [IW-1:0] greater_w [MAX_ITEMS+1];

    assign s_ready = adv;

    // Assign the item its slot in the store
    always_comb begin
        fill_base        = s_data.restart ? '0 : fill_reg;
        is_full          = (fill_base >= FILL_LIMIT);
        fill_next        = is_full ? fill_base : fill_base + IW'(1);
        head_tag.valid   = s_valid;
        head_tag.full    = is_full;
        head_tag.restart = s_data.restart;
    end

    // Hold the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (s_valid && adv) begin
            fill_reg <= fill_next;
        end
    end

    assign tag_w[0]     = head_tag;
    assign value_w[0]   = s_data.value[SW-1:0];
    assign idx_w[0]     = fill_base;
    assign lesser_w[0]  = '0;
    assign greater_w[0] = '0;

    // Row of compare cells
    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        rrcc_cell #(
            .INDEX (k),
            .SW    (SW),
            .IW    (IW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .adv         (adv),
            .tag_in      (tag_w[k]),
            .value_in    (value_w[k]),
            .idx_in      (idx_w[k]),
            .lesser_in   (lesser_w[k]),
            .greater_in  (greater_w[k]),
            .tag_out     (tag_w[k+1]),
            .value_out   (value_w[k+1]),
            .idx_out     (idx_w[k+1]),
            .lesser_out  (lesser_w[k+1]),
            .greater_out (greater_w[k+1])
        );
    end

    // Running total and result register
    rrcc_total #(
        .IW (IW)
    ) u_total (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tag_in     (tag_w[MAX_ITEMS]),
        .lesser_in  (lesser_w[MAX_ITEMS]),
        .greater_in (greater_w[MAX_ITEMS]),
        .adv        (adv),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef SYNTHESIS
    a_fill_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_LIMIT)
        else $error("fill count beyond store depth");

    a_total_mod : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.total_cost < COST_MODULUS))
        else $error("running total not reduced");

    a_cost_min : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.item_cost <= m_data.lesser_count[8:0]) ||
                     (m_data.lesser_count > 10'(COST_FIELD_MAX))) &&
                    ((m_data.item_cost <= m_data.greater_count[8:0]) ||
                     (m_data.greater_count > 10'(COST_FIELD_MAX))))
        else $error("item cost exceeds a count");

    a_full_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.full_res) |->
            (m_data.lesser_count == '0) && (m_data.greater_count == '0))
        else $error("full item carries counts");

    a_full_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_data.restart && (fill_reg == FILL_LIMIT)) |=>
            (fill_reg == FILL_LIMIT))
        else $error("full store changed its fill count");
`endif

endmodule

`default_nettype wire
